@@ rtl/core/crtc_pkg.sv @@
package crtc_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOSOL = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // micro-operations of one merge, each one pass of the divider or multiplier
  typedef enum logic [3:0] {
    OP_A1,    // run residue mod run modulus
    OP_A2,    // new residue mod new modulus
    OP_GCD,   // one Euclid step of the gcd
    OP_CHK,   // |a2 - a1| / d, remainder must be zero
    OP_N1D,   // n1 / d
    OP_N2D,   // n2 / d
    OP_LIM,   // all-ones / n2, lcm overflow bound
    OP_T,     // scaled residue difference mod n2d
    OP_INV0,  // inverse setup: n1d mod n2d
    OP_EUC,   // inverse Euclid quotient step
    OP_QS,    // q * s mod n2d for the Bezout update
    OP_K,     // t * inverse mod n2d
    OP_RES,   // n1 * k
    OP_MOD    // n1d * n2, then commit
  } op_e;

  typedef struct packed {
    logic load;
    logic first;
    logic start;
    logic fin;
    logic set_nosol;
    logic set_ovf;
    logic finish;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic run_ok;
    logic mod_zero;
    logic have_first;
    logic unit_done;
    logic gy_zero;
    logic chk_fail;
    logic ovf;
    logic r_zero;
  } stat_t;

endpackage

@@ rtl/core/crtc_div.sv @@
module crtc_div #(
  parameter int W = 63
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, rem_q, dvs_q, quo_d, rem_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    shl, sub;
  logic          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shl   = {rem_q, quo_q[W-1]};
    sub   = shl - {1'b0, dvs_q};
    ge    = shl >= {1'b0, dvs_q};
    rem_d = ge ? sub[W-1:0] : shl[W-1:0];
    quo_d = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/core/crtc_mul.sv @@
module crtc_mul #(
  parameter int W = 63
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         mod_en_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] prod_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_q, x_q, y_q, m_q;
  logic          mod_q, phase_q, busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    dbl, dbl_r, sum, sum_r;

  // msb-first double and add; the double and the add are separate steps, alternated by phase_q
  always_comb begin
    dbl   = {acc_q, 1'b0};
    sum   = {1'b0, acc_q} + {1'b0, x_q};
    dbl_r = (mod_q && dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum_r = (mod_q && sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= CW'(W);
      end else if (busy_q) begin
        phase_q <= !phase_q;
        if (phase_q) begin
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
      m_q   <= m_i;
      mod_q <= mod_en_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        acc_q <= dbl_r[W-1:0];
      end else begin
        if (y_q[W-1]) begin
          acc_q <= sum_r[W-1:0];
        end
        y_q <= {y_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ rtl/core/crtc_dp.sv @@
module crtc_dp
  import crtc_pkg::*;
#(
  parameter int W = 63
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] residue_i,
  input  logic [W-1:0] modulus_i,
  input  logic         last_i,
  input  cmd_t         cmd_i,
  output stat_t        stat_o,
  output logic [W-1:0] solution_o,
  output logic [W-1:0] combined_modulus_o,
  output logic [1:0]   status_o,
  output logic         result_valid_o
);

  logic [W-1:0] in_res_q, in_mod_q;
  logic         last_q;
  logic [W-1:0] run_res_q, run_mod_q;
  logic         have_first_q;
  logic [1:0]   run_st_q;
  logic [W-1:0] a1_q, a2_q, gx_q, gy_q, qd_q, n1d_q, n2d_q, t_q;
  logic [W-1:0] er_q, r_q, q_q, os_q, s_q, k_q, nres_q;
  logic         chk_fail_q, ovf_q;
  logic [W-1:0] sol_q, cmod_q;
  logic [1:0]   st_q;
  logic         strobe_q;

  logic         div_start, mul_start, mul_mod;
  logic [W-1:0] div_x, div_y, mul_x, mul_y;
  logic         div_done, mul_done;
  logic [W-1:0] div_quot, div_rem, prod;
  logic         a2_ge;
  logic [W-1:0] adiff, qred, smod;

  assign a2_ge = a2_q >= a1_q;
  assign adiff = a2_ge ? a2_q - a1_q : a1_q - a2_q;
  // Euclid quotient can equal the modulus once; one subtract reduces it
  assign qred  = (q_q >= n2d_q) ? q_q - n2d_q : q_q;
  assign smod  = (os_q >= prod) ? os_q - prod : n2d_q - (prod - os_q);

  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_mod   = 1'b1;
    div_x     = run_res_q;
    div_y     = run_mod_q;
    mul_x     = qred;
    mul_y     = s_q;
    case (cmd_i.op)
      OP_A1:   begin div_start = cmd_i.start; div_x = run_res_q; div_y = run_mod_q; end
      OP_A2:   begin div_start = cmd_i.start; div_x = in_res_q;  div_y = in_mod_q;  end
      OP_GCD:  begin div_start = cmd_i.start; div_x = gx_q;      div_y = gy_q;      end
      OP_CHK:  begin div_start = cmd_i.start; div_x = adiff;     div_y = gx_q;      end
      OP_N1D:  begin div_start = cmd_i.start; div_x = run_mod_q; div_y = gx_q;      end
      OP_N2D:  begin div_start = cmd_i.start; div_x = in_mod_q;  div_y = gx_q;      end
      OP_LIM:  begin div_start = cmd_i.start; div_x = '1;        div_y = in_mod_q;  end
      OP_T:    begin div_start = cmd_i.start; div_x = qd_q;      div_y = n2d_q;     end
      OP_INV0: begin div_start = cmd_i.start; div_x = n1d_q;     div_y = n2d_q;     end
      OP_EUC:  begin div_start = cmd_i.start; div_x = er_q;      div_y = r_q;       end
      OP_QS:   begin mul_start = cmd_i.start; mul_x = qred;      mul_y = s_q;       end
      OP_K:    begin mul_start = cmd_i.start; mul_x = t_q;       mul_y = os_q;      end
      OP_RES:  begin
        mul_start = cmd_i.start; mul_mod = 1'b0; mul_x = run_mod_q; mul_y = k_q;
      end
      OP_MOD:  begin
        mul_start = cmd_i.start; mul_mod = 1'b0; mul_x = n1d_q; mul_y = in_mod_q;
      end
      default: begin end
    endcase
  end

  crtc_div #(.W(W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_x),
    .divisor_i (div_y),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  crtc_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mod_en_i(mul_mod),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .m_i     (n2d_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // running congruence and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_res_q    <= '0;
      run_mod_q    <= '0;
      have_first_q <= 1'b0;
      run_st_q     <= ST_OK;
      strobe_q     <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (cmd_i.first) begin
        run_res_q <= in_res_q;
        run_mod_q <= in_mod_q;
      end
      if (cmd_i.set_nosol) begin
        run_st_q <= ST_NOSOL;
      end
      if (cmd_i.set_ovf) begin
        run_st_q <= ST_OVF;
      end
      if (cmd_i.fin && cmd_i.op == OP_MOD) begin
        run_res_q <= nres_q;
        run_mod_q <= prod;
      end
      if (cmd_i.finish) begin
        have_first_q <= 1'b1;
        if (last_q) begin
          strobe_q     <= 1'b1;
          run_res_q    <= '0;
          run_mod_q    <= '0;
          have_first_q <= 1'b0;
          run_st_q     <= ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_res_q <= residue_i;
      in_mod_q <= modulus_i;
      last_q   <= last_i;
    end
    if (cmd_i.finish && last_q) begin
      st_q <= run_st_q;
      if (run_st_q == ST_NOSOL) begin
        sol_q  <= '0;
        cmod_q <= '0;
      end else begin
        sol_q  <= run_res_q;
        cmod_q <= run_mod_q;
      end
    end
    if (cmd_i.fin) begin
      case (cmd_i.op)
        OP_A1:  a1_q <= div_rem;
        OP_A2:  begin
          a2_q <= div_rem;
          gx_q <= run_mod_q;
          gy_q <= in_mod_q;
        end
        OP_GCD: begin
          gx_q <= gy_q;
          gy_q <= div_rem;
        end
        OP_CHK: begin
          qd_q       <= div_quot;
          chk_fail_q <= div_rem != '0;
        end
        OP_N1D: n1d_q <= div_quot;
        OP_N2D: n2d_q <= div_quot;
        OP_LIM: ovf_q <= n1d_q > div_quot;
        OP_T:   t_q <= a2_ge ? div_rem : ((div_rem == '0) ? '0 : n2d_q - div_rem);
        OP_INV0: begin
          er_q <= div_rem;
          r_q  <= n2d_q;
          os_q <= (n2d_q == W'(1)) ? '0 : W'(1);
          s_q  <= '0;
        end
        OP_EUC: begin
          er_q <= r_q;
          r_q  <= div_rem;
          q_q  <= div_quot;
        end
        OP_QS: begin
          os_q <= s_q;
          s_q  <= smod;
        end
        OP_K:   k_q <= prod;
        OP_RES: nres_q <= a1_q + prod;
        default: begin end
      endcase
    end
  end

  always_comb begin
    stat_o.run_ok     = run_st_q == ST_OK;
    stat_o.mod_zero   = in_mod_q == '0;
    stat_o.have_first = have_first_q;
    stat_o.unit_done  = div_done || mul_done;
    stat_o.gy_zero    = gy_q == '0;
    stat_o.chk_fail   = chk_fail_q;
    stat_o.ovf        = ovf_q;
    stat_o.r_zero     = r_q == '0;
  end

  assign solution_o         = sol_q;
  assign combined_modulus_o = cmod_q;
  assign status_o           = st_q;
  assign result_valid_o     = strobe_q;

endmodule

@@ rtl/core/crtc_ctrl.sv @@
module crtc_ctrl
  import crtc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DISP  = 6'b000010,
    S_ISSUE = 6'b000100,
    S_WAIT  = 6'b001000,
    S_NEXT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat_i.run_ok) begin
          state_d = S_DONE;
        end else if (stat_i.mod_zero) begin
          cmd_o.set_nosol = 1'b1;
          state_d         = S_DONE;
        end else if (!stat_i.have_first) begin
          cmd_o.first = 1'b1;
          state_d     = S_DONE;
        end else begin
          op_d    = OP_A1;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.unit_done) begin
          cmd_o.fin = 1'b1;
          state_d   = S_NEXT;
        end
      end
      S_NEXT: begin
        state_d = S_ISSUE;
        case (op_q)
          OP_A1:   op_d = OP_A2;
          OP_A2:   op_d = OP_GCD;
          OP_GCD:  op_d = stat_i.gy_zero ? OP_CHK : OP_GCD;
          OP_CHK: begin
            if (stat_i.chk_fail) begin
              cmd_o.set_nosol = 1'b1;
              state_d         = S_DONE;
            end else begin
              op_d = OP_N1D;
            end
          end
          OP_N1D:  op_d = OP_N2D;
          OP_N2D:  op_d = OP_LIM;
          OP_LIM: begin
            if (stat_i.ovf) begin
              cmd_o.set_ovf = 1'b1;
              state_d       = S_DONE;
            end else begin
              op_d = OP_T;
            end
          end
          OP_T:    op_d = OP_INV0;
          OP_INV0: op_d = stat_i.r_zero ? OP_K : OP_EUC;
          OP_EUC:  op_d = OP_QS;
          OP_QS:   op_d = stat_i.r_zero ? OP_K : OP_EUC;
          OP_K:    op_d = OP_RES;
          OP_RES:  op_d = OP_MOD;
          OP_MOD:  state_d = S_DONE;
          default: state_d = S_DONE;
        endcase
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_A1;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

@@ rtl/core/crt_congruence_combiner_core.sv @@
// Combines a stream of congruences x = residue (mod modulus), moduli not
// necessarily coprime, into one congruence x = solution (mod combined_modulus).
// Input: a word is taken at a rising edge with start high and busy low;
// busy rises in the next cycle and stays high until the word is processed.
// Output: only a word with last_i high produces a result, shown for one cycle
// with result_valid_o high; the receiver cannot stall it. status_o is 0 ok,
// 1 no solution (solution and modulus zero), 2 lcm overflow (last pair that
// fitted). After a last word the running state starts a new system.
// A word that needs no merge (first of a system, zero modulus, or any word
// after a failure) passes only through the dispatch and done states. A merge
// adds passes through one shared bit-serial divider and one double-and-add
// multiplier: (8 + G + E) divides and (E + 3) multiplies, G being the gcd
// steps and E the modular inverse steps (each at most about 1.44*VALUE_BITS).
// The result strobe is registered from the last word's done state, and a new
// start is accepted while it is high.
// Reset clears the running congruence, its status and the strobe; no result pending.
module crt_congruence_combiner_core
  import crtc_pkg::*;
#(
  parameter int VALUE_BITS = 63
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] residue_i,
  input  logic [VALUE_BITS-1:0] modulus_i,
  input  logic                  last_i,
  output logic                  result_valid_o,
  output logic [VALUE_BITS-1:0] solution_o,
  output logic [VALUE_BITS-1:0] combined_modulus_o,
  output logic [1:0]            status_o
);

  cmd_t  cmd;
  stat_t stat;

  crtc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  crtc_dp #(.W(VALUE_BITS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .residue_i         (residue_i),
    .modulus_i         (modulus_i),
    .last_i            (last_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .solution_o        (solution_o),
    .combined_modulus_o(combined_modulus_o),
    .status_o          (status_o),
    .result_valid_o    (result_valid_o)
  );

endmodule

@@ sim/crt_congruence_combiner_core_tb.sv @@
module crt_congruence_combiner_core_tb;
  import crtc_pkg::*;

  localparam int VB = 63;
  localparam logic [63:0] VMASK = (64'd1 << VB) - 64'd1;
  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 730;

  typedef logic [VB-1:0] val_t;

  typedef struct {
    val_t       sol;
    val_t       cmod;
    logic [1:0] st;
  } crt_result_t;

  typedef struct {
    logic [63:0] res;
    logic [63:0] modv;
    logic        last;
    logic        typed;  // expected result given in the row
    val_t        sol;
    val_t        cmod;
    logic [1:0]  st;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  val_t       residue_i = '0;
  val_t       modulus_i = '0;
  logic       last_i = 1'b0;
  logic       result_valid_o;
  val_t       solution_o;
  val_t       combined_modulus_o;
  logic [1:0] status_o;

  crt_result_t solutions_q[$];
  int          fail_cnt = 0;
  int          idle_cnt = 0;

  // running congruence of the predictor
  logic [63:0] acc_res, acc_mod;
  logic        acc_first;
  logic [1:0]  acc_st;

  crt_congruence_combiner_core #(.VALUE_BITS(VB)) dut (
    .clk_i, .rst_ni, .start, .busy, .residue_i, .modulus_i, .last_i,
    .result_valid_o, .solution_o, .combined_modulus_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] p;
    p = 128'(x % m) * 128'(y % m);
    return 64'(p % 128'(m));
  endfunction

  function automatic logic [63:0] submod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x >= y) ? x - y : m - (y - x);
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [63:0] invmod(logic [63:0] v, logic [63:0] n);
    logic [63:0] ro, r, so, s, q, t;
    ro = v % n;
    r = n;
    so = 64'd1 % n;
    s = 0;
    while (r != 0) begin
      q = ro / r;
      t = ro - q * r;
      ro = r;
      r = t;
      t = submod(so, mulmod(q, s, n), n);
      so = s;
      s = t;
    end
    return so % n;
  endfunction

  task automatic merge_congruence(logic [63:0] a2, logic [63:0] n2);
    logic [63:0] n1, a1, d, n1d, n2d, t, k;
    n1 = acc_mod;
    a1 = acc_res % n1;
    a2 = a2 % n2;
    d = gcd64(n1, n2);
    if (a1 % d != a2 % d) begin
      acc_st = ST_NOSOL;
      return;
    end
    n1d = n1 / d;
    n2d = n2 / d;
    if (n1d > VMASK / n2) begin
      acc_st = ST_OVF;
      return;
    end
    if (a2 >= a1) t = ((a2 - a1) / d) % n2d;
    else t = (n2d - ((a1 - a2) / d) % n2d) % n2d;
    k = mulmod(t, invmod(n1d, n2d), n2d);
    acc_res = a1 + n1 * k;
    acc_mod = n1d * n2;
  endtask

  task automatic clear_congruence();
    acc_res = 0;
    acc_mod = 0;
    acc_first = 1'b0;
    acc_st = ST_OK;
  endtask

  task automatic predict_word(val_t r, val_t m, logic lst, output logic has, output crt_result_t o);
    has = 1'b0;
    o = '{default: '0};
    if (acc_st == ST_OK) begin
      if (m == 0) acc_st = ST_NOSOL;
      else if (!acc_first) begin
        acc_res = 64'(r);
        acc_mod = 64'(m);
      end else merge_congruence(64'(r), 64'(m));
    end
    acc_first = 1'b1;
    if (lst) begin
      has = 1'b1;
      if (acc_st != ST_NOSOL) begin
        o.sol = acc_res[VB-1:0];
        o.cmod = acc_mod[VB-1:0];
      end
      o.st = acc_st;
      clear_congruence();
    end
  endtask

  // one word through the handshake; returns once accepted
  task automatic send_word(val_t r, val_t m, logic lst);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    residue_i <= r;
    modulus_i <= m;
    last_i <= lst;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (solutions_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic val_t rand_val();
    return val_t'({$urandom, $urandom});
  endfunction

  function automatic val_t rand_mod(int bits);
    val_t v;
    v = rand_val() >> (VB - bits);
    return (v == 0) ? val_t'(1) : v;
  endfunction

  task automatic run_word(val_t r, val_t m, logic lst);
    logic has;
    crt_result_t o;
    send_word(r, m, lst);
    predict_word(r, m, lst, has, o);
    if (has) solutions_q.push_back(o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (solutions_q.size() == 0) begin
        $error("unexpected result word: solution %h", solution_o);
        fail_cnt++;
      end else begin
        crt_result_t e;
        e = solutions_q.pop_front();
        if (solution_o !== e.sol) begin
          $error("solution: expected %h got %h", e.sol, solution_o);
          fail_cnt++;
        end
        if (combined_modulus_o !== e.cmod) begin
          $error("combined_modulus: expected %h got %h", e.cmod, combined_modulus_o);
          fail_cnt++;
        end
        if (status_o !== e.st) begin
          $error("status: expected %0d got %0d", e.st, status_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    int n;
    int len;
    int kind;
    int bits;
    val_t x;
    val_t r;
    val_t m;
    logic has;
    crt_result_t o;

    rows = '{
      '{0, 1, 1, 1, 0, 1, ST_OK},
      '{VMASK, 1, 1, 1, val_t'(VMASK), 1, ST_OK},      // residue above modulus
      '{0, VMASK, 1, 1, 0, val_t'(VMASK), ST_OK},
      '{7, 0, 1, 1, 0, 0, ST_NOSOL},                  // zero modulus
      '{2, 3, 0, 0, 0, 0, ST_OK},
      '{3, 5, 1, 1, 8, 15, ST_OK},
      '{1, 4, 0, 0, 0, 0, ST_OK},
      '{2, 6, 1, 1, 0, 0, ST_NOSOL},                  // residues clash mod gcd
      '{3, 4, 0, 0, 0, 0, ST_OK},
      '{1, 6, 1, 1, 7, 12, ST_OK},
      '{5, VMASK, 0, 0, 0, 0, ST_OK},
      '{3, VMASK - 1, 1, 1, 5, val_t'(VMASK), ST_OVF},  // lcm overflow
      '{1, 64'd1 << 62, 0, 0, 0, 0, ST_OK},
      '{1, 3, 0, 0, 0, 0, ST_OK},
      '{9, 0, 1, 1, 1, val_t'(64'd1 << 62), ST_OVF},    // ignored after overflow
      '{4, 0, 0, 0, 0, 0, ST_OK},
      '{VMASK, 5, 1, 1, 0, 0, ST_NOSOL},
      '{VMASK, 1000003, 0, 0, 0, 0, ST_OK},
      '{VMASK - 5, 999983, 1, 0, 0, 0, ST_OK},
      '{1, 2, 0, 0, 0, 0, ST_OK},
      '{0, 2, 0, 0, 0, 0, ST_OK},
      '{1, VMASK, 1, 1, 0, 0, ST_NOSOL},              // no solution stays
      '{64'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0, 0, 0, 0, ST_OK},
      '{64'h5555_5555_5555_5554, 64'h2AAA_AAAA_AAAA_AAAA, 1, 0, 0, 0, ST_OK}
    };

    clear_congruence();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_word(rows[i].res[VB-1:0], rows[i].modv[VB-1:0], rows[i].last);
      predict_word(rows[i].res[VB-1:0], rows[i].modv[VB-1:0], rows[i].last, has, o);
      if (has) begin
        if (rows[i].typed) solutions_q.push_back('{rows[i].sol, rows[i].cmod, rows[i].st});
        else solutions_q.push_back(o);
      end
    end
    drain_results();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n > RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 6) drain_results();
      len = $urandom_range(1, 5);
      kind = $urandom_range(0, 99);
      x = rand_val();
      for (int j = 0; j < len; j++) begin
        bits = (kind < 85) ? $urandom_range(1, 16) : $urandom_range(17, VB);
        m = rand_mod(bits);
        if (kind < 70) begin
          r = x % m;
          if ($urandom_range(0, 3) == 0 && bits < 40) r = r + m * val_t'($urandom_range(1, 1000));
        end else if (kind < 80) begin
          r = rand_val();
        end else if (kind < 85) begin
          r = x % m;
          if ($urandom_range(0, 2) == 0) m = 0;
        end else begin
          r = (kind < 95) ? x % m : rand_val();
        end
        run_word(r, m, j == len - 1);
        n++;
      end
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/crtc_pkg.sv
rtl/core/crtc_div.sv
rtl/core/crtc_mul.sv
rtl/core/crtc_dp.sv
rtl/core/crtc_ctrl.sv
rtl/core/crt_congruence_combiner_core.sv
sim/crt_congruence_combiner_core_tb.sv
